FILE: rtl/core/kft_pkg.sv
// ----------------------------------------------------------------------------
// kft_pkg
// types, request and status codes and defaults for the keyed flag table
// ----------------------------------------------------------------------------
`default_nettype none

package kft_pkg;

  localparam int unsigned KFT_TABLE_ENTRIES = 16;
  localparam int unsigned KFT_KEY_WIDTH     = 22;
  localparam int unsigned KFT_COUNT_MAX     = 31;

  localparam logic [2:0] KFT_REQ_ADD     = 3'd0;
  localparam logic [2:0] KFT_REQ_REMOVE  = 3'd1;
  localparam logic [2:0] KFT_REQ_SET_ATT = 3'd2;
  localparam logic [2:0] KFT_REQ_SET_STP = 3'd3;
  localparam logic [2:0] KFT_REQ_LOOKUP  = 3'd4;

  localparam logic [1:0] KFT_ST_OK        = 2'd0;
  localparam logic [1:0] KFT_ST_FULL      = 2'd1;
  localparam logic [1:0] KFT_ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [21:0] key_id;
    logic        flag_value;
  } kft_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic       attached_out;
    logic       stopped_out;
    logic [4:0] active_count;
  } kft_rsp_t;

  // transaction token walking the cell chain
  typedef struct packed {
    logic       live;
    logic       done;
    logic [2:0] req_type;
    logic       flag;
    logic       att;
    logic       stp;
  } kft_tok_t;

endpackage

`default_nettype wire

FILE: rtl/core/kft_cell.sv
// ----------------------------------------------------------------------------
// kft_cell
// one table entry; acts on the passing token and forwards it to the next cell
// ----------------------------------------------------------------------------
`default_nettype none

module kft_cell #(
  parameter int unsigned KEY_WIDTH = kft_pkg::KFT_KEY_WIDTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire kft_pkg::kft_tok_t    tok_i,
  input  wire logic [KEY_WIDTH-1:0] key_i,
  output kft_pkg::kft_tok_t         tok_o,
  output logic [KEY_WIDTH-1:0]      key_o
);
  import kft_pkg::*;

  logic                 valid_q, valid_d;
  logic                 att_q, att_d;
  logic                 stp_q, stp_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  kft_tok_t             tok_q, tok_d;
  logic [KEY_WIDTH-1:0] fwd_key_q;
  logic                 match;
  logic                 hit;

  assign match = valid_q && (key_q == key_i);

  always_comb begin
    hit = 1'b0;
    if (en_i && tok_i.live && !tok_i.done) begin
      case (tok_i.req_type) inside
        KFT_REQ_ADD: hit = !valid_q;
        KFT_REQ_REMOVE, KFT_REQ_SET_ATT, KFT_REQ_SET_STP, KFT_REQ_LOOKUP: hit = match;
        default: hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    valid_d = valid_q;
    att_d   = att_q;
    stp_d   = stp_q;
    key_d   = key_q;
    tok_d   = tok_i;
    if (hit) begin
      tok_d.done = 1'b1;
      case (tok_i.req_type)
        KFT_REQ_ADD: begin
          valid_d = 1'b1;
          key_d   = key_i;
          att_d   = 1'b0;
          stp_d   = 1'b0;
        end
        KFT_REQ_REMOVE: begin
          tok_d.att = att_q;
          tok_d.stp = stp_q;
          valid_d   = 1'b0;
          att_d     = 1'b0;
          stp_d     = 1'b0;
        end
        KFT_REQ_SET_ATT: begin
          att_d     = tok_i.flag;
          tok_d.att = tok_i.flag;
          tok_d.stp = stp_q;
        end
        KFT_REQ_SET_STP: begin
          stp_d     = tok_i.flag;
          tok_d.att = att_q;
          tok_d.stp = tok_i.flag;
        end
        default: begin
          tok_d.att = att_q;
          tok_d.stp = stp_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      att_q   <= 1'b0;
      stp_q   <= 1'b0;
      tok_q   <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
      att_q   <= att_d;
      stp_q   <= stp_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q     <= key_d;
      fwd_key_q <= key_i;
    end
  end

  assign tok_o = tok_q;
  assign key_o = fwd_key_q;

endmodule

`default_nettype wire

FILE: rtl/core/keyed_flag_table_core.sv
// ----------------------------------------------------------------------------
// keyed_flag_table_core
// fully associative keyed table built as a chain of entry cells
// ----------------------------------------------------------------------------
// the request token walks the cell chain one entry per cycle while the output is
//   not held by back-pressure; the response is registered after the last cell
// a new transaction is accepted only after the previous one has left the chain
// reset: valid bits, flags and the entry count clear at once; keys are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_flag_table_core #(
  parameter int unsigned TABLE_ENTRIES = kft_pkg::KFT_TABLE_ENTRIES,
  parameter int unsigned KEY_WIDTH     = kft_pkg::KFT_KEY_WIDTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire kft_pkg::kft_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output kft_pkg::kft_rsp_t      out_rsp_o
);
  import kft_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  kft_tok_t             tok_chain [TABLE_ENTRIES+1];
  logic [KEY_WIDTH-1:0] key_chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] live_vec;

  logic            busy_q, busy_d;
  logic            out_valid_q, out_valid_d;
  kft_rsp_t        out_rsp_q, out_rsp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic            adv;
  logic            load;
  kft_tok_t        last;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    tok_chain[0]          = '0;
    tok_chain[0].live     = accept;
    tok_chain[0].req_type = in_req_i.req_type;
    tok_chain[0].flag     = in_req_i.flag_value;
  end
  assign key_chain[0] = KEY_WIDTH'(in_req_i.key_id);

  assign last = tok_chain[TABLE_ENTRIES];
  assign adv  = !(last.live && out_valid_q && !out_ready_i);
  assign load = last.live && adv;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    kft_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .tok_i (tok_chain[g]),
      .key_i (key_chain[g]),
      .tok_o (tok_chain[g+1]),
      .key_o (key_chain[g+1])
    );
    assign live_vec[g] = tok_chain[g+1].live;
  end

  always_comb begin
    cnt_d       = cnt_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      busy_d                 = 1'b0;
      out_valid_d            = 1'b1;
      out_rsp_d              = '0;
      out_rsp_d.status       = KFT_ST_OK;
      case (last.req_type) inside
        KFT_REQ_ADD: begin
          if (last.done) begin
            cnt_d = cnt_q + CntW'(1);
          end else begin
            out_rsp_d.status = KFT_ST_FULL;
          end
        end
        KFT_REQ_REMOVE, KFT_REQ_SET_ATT, KFT_REQ_SET_STP, KFT_REQ_LOOKUP: begin
          if (last.done) begin
            out_rsp_d.found        = 1'b1;
            out_rsp_d.attached_out = last.att;
            out_rsp_d.stopped_out  = last.stp;
            if (last.req_type == KFT_REQ_REMOVE) begin
              cnt_d = cnt_q - CntW'(1);
            end
          end else begin
            out_rsp_d.status = KFT_ST_NOT_FOUND;
          end
        end
        default: out_rsp_d.status = KFT_ST_OK;
      endcase
      if (32'(cnt_d) > 32'(KFT_COUNT_MAX)) begin
        out_rsp_d.active_count = 5'(KFT_COUNT_MAX);
      end else begin
        out_rsp_d.active_count = 5'(cnt_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef NO_ASSERTIONS
  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(live_vec))
    else $error("more than one transaction in the cell chain");

  a_idle_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (live_vec == '0))
    else $error("token in chain while idle");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && ((TABLE_ENTRIES == 1) ? live_vec[0] :
                           !out_valid_q || $past(out_valid_q))))
    else $error("accepted transaction lost");
`endif

endmodule

`default_nettype wire
